@@ hw/rtl/bba_pkg.sv @@
package bba_pkg;

    localparam int WORD_W = 64;
    localparam int BIT_W  = 6;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_START = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_BLOCKS = 1'b1;

    // request codes
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED   = 2'd1;
    localparam logic [1:0] ST_DOUBLE_FREE = 2'd2;
    localparam logic [1:0] ST_RANGE       = 2'd3;

    typedef enum logic [6:0] {
        S_CLEAR    = 7'b0000001,
        S_IDLE     = 7'b0000010,
        S_ROW      = 7'b0000100,
        S_SUM      = 7'b0001000,
        S_MAP      = 7'b0010000,
        S_FREE_CHK = 7'b0100000,
        S_FREE_WR  = 7'b1000000
    } state_t;

    // lowest clear bit of a 64-bit word
    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] idx;
    } find_t;

endpackage

@@ hw/rtl/bba_zfind.sv @@
module bba_zfind (
    input  logic [bba_pkg::WORD_W-1:0] bits,
    output bba_pkg::find_t             result
);
    import bba_pkg::*;

    // priority encode the lowest zero bit
    always_comb
    begin
        result = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (!bits[i])
            begin
                result.found = 1'b1;
                result.idx   = BIT_W'(i);
            end
        end
    end

endmodule

@@ hw/rtl/bitmap_block_allocator.sv @@
// Flow: an allocate steps S_ROW, S_SUM, S_MAP and writes the result word there
//   (exhausted from S_ROW or S_SUM); a free steps S_FREE_CHK, S_FREE_WR (out of
//   range from S_FREE_CHK). A state that emits waits while the output word stalls.
// Throughput: one word at a time, set by the registered summary, then map reads.
// Reset: asynchronous, active low; a clearing pass then zeroes the map memory,
//   one word a cycle, through all MAX_MAP_BLOCKS * WORDS_PER_MAP_BLOCK words (256
//   by default) while in_ready stays low. Configuration writes are taken as ever.
module bitmap_block_allocator #(
    parameter int WORDS_PER_MAP_BLOCK = 64,
    parameter int MAX_MAP_BLOCKS      = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [bba_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bba_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              action,
    input  logic [31:0]                       block_number,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [31:0]                       granted_block,
    output logic [1:0]                        status
);
    import bba_pkg::*;

    localparam int TOTAL_WORDS = MAX_MAP_BLOCKS * WORDS_PER_MAP_BLOCK;
    // the full-word summary is held as rows of 64 flags, one row per 64 map words
    localparam int NUM_ROWS    = (TOTAL_WORDS + WORD_W - 1) / WORD_W;
    localparam int WADDR_W     = (TOTAL_WORDS > 1) ? $clog2(TOTAL_WORDS) : 1;
    localparam int ROW_W       = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int WIDX_W      = ROW_W + BIT_W;
    localparam int NW_W        = $clog2(TOTAL_WORDS + 1);

    localparam logic [WADDR_W-1:0] CLR_LAST  = WADDR_W'(TOTAL_WORDS - 1);
    localparam logic [WADDR_W-1:0] ROWS_LAST = WADDR_W'(NUM_ROWS - 1);

    // ---------------------------------------------------------------- state
    state_t                 state_reg, state_next;
    logic [WADDR_W-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [31:0]            data_start_reg;
    logic [2:0]             map_blocks_reg;
    logic [NUM_ROWS-1:0]    row_full_reg;

    // request and working registers (payload, no reset)
    logic [31:0]            blk_reg, blk_next;
    logic [ROW_W-1:0]       row_reg, row_next;
    logic [BIT_W-1:0]       j_reg, j_next;
    logic [BIT_W-1:0]       k_reg, k_next;

    // output word register
    logic                   out_valid_reg;
    logic [31:0]            granted_reg;
    logic [1:0]             status_reg;

    // memories: map words and full-word summary rows
    logic [WORD_W-1:0]      map_mem [TOTAL_WORDS];
    logic [WORD_W-1:0]      sum_mem [NUM_ROWS];
    logic [WORD_W-1:0]      map_rd_reg;
    logic [WORD_W-1:0]      sum_rd_reg;

    logic                   map_we, map_re;
    logic [WADDR_W-1:0]     map_waddr, map_raddr;
    logic [WORD_W-1:0]      map_wdata;
    logic                   sum_we, sum_re;
    logic [ROW_W-1:0]       sum_waddr, sum_raddr;
    logic [WORD_W-1:0]      sum_wdata;
    logic                   row_we, row_wval;

    logic                   emit, emit_ok;
    logic [31:0]            emit_granted;
    logic [1:0]             emit_status;

    // ------------------------------------------------------- active map size
    logic [31:0]            nwords_wide;
    logic [NW_W-1:0]        nwords;

    // map_blocks above the maximum acts as the maximum
    assign nwords_wide = (32'(map_blocks_reg) > 32'(MAX_MAP_BLOCKS)) ? 32'(TOTAL_WORDS)
                       : 32'(map_blocks_reg) * 32'(WORDS_PER_MAP_BLOCK);
    assign nwords      = nwords_wide[NW_W-1:0];

    // ---------------------------------------------- first summary row not full
    logic                   row_hit;
    logic [ROW_W-1:0]       row_sel;

    always_comb
    begin
        row_hit = 1'b0;
        row_sel = '0;
        for (int r = NUM_ROWS - 1; r >= 0; r--)
        begin
            if (!row_full_reg[r] && (32'(r) * 32'(WORD_W) < 32'(nwords)))
            begin
                row_hit = 1'b1;
                row_sel = ROW_W'(r);
            end
        end
    end

    // ------------------------------------------- per-row active / existing words
    logic [WORD_W-1:0]      act_mask;
    logic [WORD_W-1:0]      exist_mask;
    logic [WIDX_W-1:0]      mask_widx;

    always_comb
    begin
        act_mask   = '0;
        exist_mask = '0;
        mask_widx  = '0;
        for (int j = 0; j < WORD_W; j++)
        begin
            mask_widx     = {row_reg, BIT_W'(j)};
            act_mask[j]   = 32'(mask_widx) < 32'(nwords);
            exist_mask[j] = 32'(mask_widx) < 32'(TOTAL_WORDS);
        end
    end

    // ---------------------------------------------------------- bit searches
    find_t                  sum_find;
    find_t                  map_find;
    logic [WORD_W-1:0]      sum_search;

    // words outside the active map count as full
    assign sum_search = sum_rd_reg | ~act_mask;

    bba_zfind u_sum_find (
        .bits   (sum_search),
        .result (sum_find)
    );

    bba_zfind u_map_find (
        .bits   (map_rd_reg),
        .result (map_find)
    );

    // ----------------------------------------------------- allocate datapath
    logic [WIDX_W-1:0]      alloc_widx;
    logic [WIDX_W-1:0]      grant_widx;
    logic [WORD_W-1:0]      map_set, sum_set;
    logic                   word_now_full, row_now_full;

    assign alloc_widx    = {row_reg, sum_find.idx};
    assign grant_widx    = {row_reg, j_reg};
    assign map_set       = map_rd_reg | (WORD_W'(1) << map_find.idx);
    assign word_now_full = &map_set;
    assign sum_set       = sum_rd_reg | (WORD_W'(1) << j_reg);
    assign row_now_full  = &(sum_set | ~exist_mask);

    // --------------------------------------------------------- free datapath
    logic [31:0]            off;
    logic                   below, past;
    logic [WIDX_W-1:0]      free_widx;
    logic [WORD_W-1:0]      map_clr, sum_clr;

    assign off       = blk_reg - data_start_reg;
    assign below     = blk_reg < data_start_reg;
    assign past      = off >= 32'({nwords, BIT_W'(0)});
    assign free_widx = off[WIDX_W+BIT_W-1:BIT_W];
    assign map_clr   = map_rd_reg & ~(WORD_W'(1) << k_reg);
    assign sum_clr   = sum_rd_reg & ~(WORD_W'(1) << j_reg);

    // ------------------------------------------------------------ control
    // a result word is written only when the output register is free or drains
    assign emit_ok  = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        blk_next     = blk_reg;
        row_next     = row_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        map_we       = 1'b0;
        map_waddr    = '0;
        map_wdata    = '0;
        map_re       = 1'b0;
        map_raddr    = '0;
        sum_we       = 1'b0;
        sum_waddr    = '0;
        sum_wdata    = '0;
        sum_re       = 1'b0;
        sum_raddr    = '0;
        row_we       = 1'b0;
        row_wval     = 1'b0;
        emit         = 1'b0;
        emit_granted = '0;
        emit_status  = ST_OK;

        case (state_reg)
            S_CLEAR:
            begin
                // sweep zeros through the map; the summary rows go along
                map_we       = 1'b1;
                map_waddr    = clr_cnt_reg;
                if (clr_cnt_reg <= ROWS_LAST)
                begin
                    sum_we    = 1'b1;
                    sum_waddr = clr_cnt_reg[ROW_W-1:0];
                end
                clr_cnt_next = clr_cnt_reg + WADDR_W'(1);
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    blk_next   = block_number;
                    state_next = (action == ACT_FREE) ? S_FREE_CHK : S_ROW;
                end
            end

            S_ROW:
            begin
                if (!row_hit)
                begin
                    if (emit_ok)
                    begin
                        emit        = 1'b1;
                        emit_status = ST_EXHAUSTED;
                        state_next  = S_IDLE;
                    end
                end
                else
                begin
                    sum_re     = 1'b1;
                    sum_raddr  = row_sel;
                    row_next   = row_sel;
                    state_next = S_SUM;
                end
            end

            S_SUM:
            begin
                // no clear flag in the active part means the last active row is full
                if (!sum_find.found)
                begin
                    if (emit_ok)
                    begin
                        emit        = 1'b1;
                        emit_status = ST_EXHAUSTED;
                        state_next  = S_IDLE;
                    end
                end
                else
                begin
                    map_re     = 1'b1;
                    map_raddr  = alloc_widx[WADDR_W-1:0];
                    j_next     = sum_find.idx;
                    state_next = S_MAP;
                end
            end

            S_MAP:
            begin
                if (emit_ok)
                begin
                    map_we    = 1'b1;
                    map_waddr = grant_widx[WADDR_W-1:0];
                    map_wdata = map_set;
                    if (word_now_full)
                    begin
                        sum_we    = 1'b1;
                        sum_waddr = row_reg;
                        sum_wdata = sum_set;
                        row_we    = 1'b1;
                        row_wval  = row_now_full;
                    end
                    emit         = 1'b1;
                    emit_status  = ST_OK;
                    emit_granted = data_start_reg + 32'({grant_widx, map_find.idx});
                    state_next   = S_IDLE;
                end
            end

            S_FREE_CHK:
            begin
                if (below || past)
                begin
                    if (emit_ok)
                    begin
                        emit        = 1'b1;
                        emit_status = ST_RANGE;
                        state_next  = S_IDLE;
                    end
                end
                else
                begin
                    map_re     = 1'b1;
                    map_raddr  = free_widx[WADDR_W-1:0];
                    sum_re     = 1'b1;
                    sum_raddr  = free_widx[WIDX_W-1:BIT_W];
                    row_next   = free_widx[WIDX_W-1:BIT_W];
                    j_next     = free_widx[BIT_W-1:0];
                    k_next     = off[BIT_W-1:0];
                    state_next = S_FREE_WR;
                end
            end

            S_FREE_WR:
            begin
                if (emit_ok)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                    if (!map_rd_reg[k_reg])
                    begin
                        emit_status = ST_DOUBLE_FREE;
                    end
                    else
                    begin
                        map_we      = 1'b1;
                        map_waddr   = grant_widx[WADDR_W-1:0];
                        map_wdata   = map_clr;
                        sum_we      = 1'b1;
                        sum_waddr   = row_reg;
                        sum_wdata   = sum_clr;
                        row_we      = 1'b1;
                        row_wval    = 1'b0;
                        emit_status = ST_OK;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // --------------------------------------------------- control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            data_start_reg <= '0;
            map_blocks_reg <= 3'd4;
            row_full_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_DATA_START: data_start_reg <= cfg_data;
                    CFG_MAP_BLOCKS: map_blocks_reg <= cfg_data[2:0];
                    default:        ;
                endcase
            end
            if (row_we)
            begin
                row_full_reg[row_reg] <= row_wval;
            end
            // hold the word until taken, then drop it unless a new one lands
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // --------------------------------------------------- payload registers
    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        row_reg <= row_next;
        j_reg   <= j_next;
        k_reg   <= k_next;
        if (emit)
        begin
            granted_reg <= emit_granted;
            status_reg  <= emit_status;
        end
    end

    // --------------------------------------------------------------- memories
    // one item at a time: every write lands before the next read is issued
    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_waddr] <= map_wdata;
        end
        if (map_re)
        begin
            map_rd_reg <= map_mem[map_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_we)
        begin
            sum_mem[sum_waddr] <= sum_wdata;
        end
        if (sum_re)
        begin
            sum_rd_reg <= sum_mem[sum_raddr];
        end
    end

    assign out_valid     = out_valid_reg;
    assign granted_block = granted_reg;
    assign status        = status_reg;

endmodule

@@ hw/rtl/bba_checker.sv @@
module bba_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] granted_block,
    input logic [1:0]  status
);
    import bba_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(granted_block) && $stable(status))
        else $error("result word changed while stalled");

    // an error result never carries a block number
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> granted_block == 32'd0)
        else $error("error result with nonzero block");

    // one word in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second word accepted while busy");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .granted_block (granted_block),
    .status        (status)
);
